// File: src/ssba_pkg.sv
`default_nettype none
package ssba_pkg;

   localparam int unsigned SLOT_FIELD_W   = 10;
   localparam int unsigned SECTOR_FIELD_W = 13;
   localparam int unsigned COUNT_FIELD_W  = 11;
   localparam int unsigned ROW_BITS       = 32;
   localparam int unsigned ROW_SHIFT      = 5;
   localparam int unsigned CSR_ADDR_W     = 3;
   localparam int unsigned CSR_DATA_W     = 32;

   localparam logic [COUNT_FIELD_W-1:0] SLOT_COUNT_RESET = 11'd1024;
   localparam logic                     REG_SLOT_COUNT   = 1'b0;

   typedef enum logic {
      OP_ALLOC   = 1'b0,
      OP_RELEASE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_BAD_SLOT = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      RD_ZERO,
      RD_NEXT,
      RD_REQ
   } rd_src_type;

   typedef struct packed {
      logic       load_req;
      logic       scan_clr;
      logic       scan_inc;
      logic       rd_en;
      rd_src_type rd_src;
      logic       clear_wr;
      logic       alloc_commit;
      logic       release_commit;
      logic       out_load;
      status_type out_status;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic hit;
      logic miss_last;
      logic rel_ok;
      logic beat_last;
      logic out_free;
   } sts_type;

endpackage
`default_nettype wire

// File: src/ssba_ram.sv
`default_nettype none
module ssba_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 32,
   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: src/ssba_ctrl.sv
`default_nettype none
module ssba_ctrl
   import ssba_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic    req_op,
   output logic         req_ready,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_CHECK,
      ST_EMIT,
      ST_FULL,
      ST_BAD
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.rd_src     = RD_ZERO;
      cmd.out_status = STATUS_OK;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            cmd.scan_inc = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               cmd.scan_clr = 1'b1;
               cmd.rd_en    = 1'b1;
               if (req_op == OP_ALLOC) begin
                  cmd.rd_src = RD_ZERO;
                  state_in   = ST_SCAN;
               end else begin
                  cmd.rd_src = RD_REQ;
                  state_in   = ST_CHECK;
               end
            end
         end
         ST_SCAN: begin
            if (sts.hit) begin
               cmd.alloc_commit = 1'b1;
               state_in         = ST_EMIT;
            end else if (sts.miss_last) begin
               state_in = ST_FULL;
            end else begin
               cmd.rd_en    = 1'b1;
               cmd.rd_src   = RD_NEXT;
               cmd.scan_inc = 1'b1;
            end
         end
         ST_CHECK: begin
            if (sts.rel_ok) begin
               cmd.release_commit = 1'b1;
               state_in           = ST_EMIT;
            end else begin
               state_in = ST_BAD;
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.out_load   = 1'b1;
               cmd.out_status = STATUS_OK;
               if (sts.beat_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_FULL: begin
            if (sts.out_free) begin
               cmd.out_load   = 1'b1;
               cmd.out_status = STATUS_FULL;
               state_in       = ST_IDLE;
            end
         end
         ST_BAD: begin
            if (sts.out_free) begin
               cmd.out_load   = 1'b1;
               cmd.out_status = STATUS_BAD_SLOT;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// File: src/ssba_dpath.sv
`default_nettype none
module ssba_dpath
   import ssba_pkg::*;
#(
   parameter int unsigned MAX_SLOTS        = 1024,
   parameter int unsigned SECTORS_PER_PAGE = 8
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire cmd_type                   cmd,
   output sts_type                        sts,
   input  wire logic [COUNT_FIELD_W-1:0]  slot_count,
   input  wire logic [SLOT_FIELD_W-1:0]   req_slot_index,
   input  wire logic                      rsp_ready,
   output logic                           rsp_valid,
   output logic      [SLOT_FIELD_W-1:0]   rsp_slot,
   output logic      [SECTOR_FIELD_W-1:0] rsp_sector,
   output status_type                     rsp_status,
   output logic                           rsp_last
);

   localparam int unsigned ROWS    = (MAX_SLOTS + ROW_BITS - 1) / ROW_BITS;
   localparam int unsigned ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int unsigned LOG_MAX = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int unsigned IDX_W   = (LOG_MAX > SLOT_FIELD_W) ? LOG_MAX : SLOT_FIELD_W;
   localparam int unsigned CMP_W   = ((IDX_W > COUNT_FIELD_W) ? IDX_W : COUNT_FIELD_W) + 1;
   localparam int unsigned BEAT_W  = (SECTORS_PER_PAGE > 1) ? $clog2(SECTORS_PER_PAGE) : 1;
   localparam int unsigned SPP_W   = $clog2(SECTORS_PER_PAGE + 1);
   localparam int unsigned PROD_W  = (IDX_W + SPP_W > SECTOR_FIELD_W) ?
                                     IDX_W + SPP_W : SECTOR_FIELD_W;

   logic [ROW_W-1:0]    scan_addr_ff;
   logic [ROW_W-1:0]    scan_addr_in;
   logic [IDX_W-1:0]    slot_ff;
   logic [IDX_W-1:0]    slot_in;
   logic [BEAT_W-1:0]   beat_ff;
   logic [BEAT_W-1:0]   beat_in;

   logic                rsp_valid_ff;
   logic [SLOT_FIELD_W-1:0]   rsp_slot_ff;
   logic [SECTOR_FIELD_W-1:0] rsp_sector_ff;
   status_type          rsp_status_ff;
   logic                rsp_last_ff;

   logic [CMP_W-1:0]    limit;
   logic [CMP_W-1:0]    count_ext;
   logic [CMP_W-1:0]    base;
   logic [ROW_BITS-1:0] rd_data;
   logic [ROW_BITS-1:0] free_mask;
   logic [ROW_BITS-1:0] low_onehot;
   logic [ROW_SHIFT-1:0] low_idx;
   logic [ROW_BITS-1:0] bit_mask;
   logic [ROW_W-1:0]    slot_row;
   logic [ROW_W-1:0]    req_row;
   logic [IDX_W-1:0]    req_ext;
   logic [ROW_W-1:0]    rd_addr;
   logic                wr_en;
   logic [ROW_W-1:0]    wr_addr;
   logic [ROW_BITS-1:0] wr_data;
   logic [PROD_W-1:0]   sector_full;
   logic                beat_last;

   assign count_ext = CMP_W'(slot_count);
   assign limit     = (count_ext > CMP_W'(MAX_SLOTS)) ? CMP_W'(MAX_SLOTS) : count_ext;
   assign base      = CMP_W'({scan_addr_ff, {ROW_SHIFT{1'b0}}});
   assign req_ext   = IDX_W'(req_slot_index);
   assign req_row   = req_ext[ROW_W+ROW_SHIFT-1:ROW_SHIFT];
   assign slot_row  = slot_ff[ROW_W+ROW_SHIFT-1:ROW_SHIFT];
   assign bit_mask  = ROW_BITS'(1) << slot_ff[ROW_SHIFT-1:0];

   always_comb begin
      for (int j = 0; j < ROW_BITS; j++) begin
         free_mask[j] = !rd_data[j] && ((base | CMP_W'(j)) < limit);
      end
   end

   assign low_onehot = free_mask & (~free_mask + ROW_BITS'(1));

   always_comb begin
      low_idx = '0;
      for (int j = 0; j < ROW_BITS; j++) begin
         if (low_onehot[j]) begin
            low_idx = low_idx | ROW_SHIFT'(j);
         end
      end
   end

   always_comb begin
      unique case (cmd.rd_src)
         RD_ZERO: rd_addr = '0;
         RD_NEXT: rd_addr = scan_addr_ff + ROW_W'(1);
         RD_REQ:  rd_addr = req_row;
         default: rd_addr = '0;
      endcase
   end

   assign wr_en   = cmd.clear_wr || cmd.alloc_commit || cmd.release_commit;
   assign wr_addr = cmd.release_commit ? slot_row : scan_addr_ff;
   always_comb begin
      if (cmd.clear_wr) begin
         wr_data = '0;
      end else if (cmd.alloc_commit) begin
         wr_data = rd_data | low_onehot;
      end else begin
         wr_data = rd_data & ~bit_mask;
      end
   end

   ssba_ram #(
      .WIDTH (ROW_BITS),
      .DEPTH (ROWS)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign beat_last   = (beat_ff == BEAT_W'(SECTORS_PER_PAGE - 1));
   assign sector_full = PROD_W'(slot_ff) * PROD_W'(SECTORS_PER_PAGE) + PROD_W'(beat_ff);

   assign sts.clear_last = (scan_addr_ff == ROW_W'(ROWS - 1));
   assign sts.hit        = |free_mask;
   assign sts.miss_last  = (scan_addr_ff == ROW_W'(ROWS - 1)) ||
                           ((base + CMP_W'(ROW_BITS)) >= limit);
   assign sts.rel_ok     = rd_data[slot_ff[ROW_SHIFT-1:0]] && (CMP_W'(slot_ff) < limit);
   assign sts.beat_last  = beat_last;
   assign sts.out_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      scan_addr_in = scan_addr_ff;
      if (cmd.scan_clr) begin
         scan_addr_in = '0;
      end else if (cmd.scan_inc) begin
         scan_addr_in = scan_addr_ff + ROW_W'(1);
      end
      slot_in = slot_ff;
      if (cmd.load_req) begin
         slot_in = req_ext;
      end else if (cmd.alloc_commit) begin
         slot_in = IDX_W'(base | CMP_W'(low_idx));
      end
      beat_in = beat_ff;
      if (cmd.load_req) begin
         beat_in = '0;
      end else if (cmd.out_load && cmd.out_status == STATUS_OK) begin
         beat_in = beat_ff + BEAT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_addr_ff <= '0;
         beat_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         scan_addr_ff <= scan_addr_in;
         beat_ff      <= beat_in;
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      slot_ff <= slot_in;
      if (cmd.out_load) begin
         rsp_status_ff <= cmd.out_status;
         unique case (cmd.out_status)
            STATUS_OK: begin
               rsp_slot_ff   <= slot_ff[SLOT_FIELD_W-1:0];
               rsp_sector_ff <= sector_full[SECTOR_FIELD_W-1:0];
               rsp_last_ff   <= beat_last;
            end
            STATUS_FULL: begin
               rsp_slot_ff   <= '0;
               rsp_sector_ff <= '0;
               rsp_last_ff   <= 1'b1;
            end
            default: begin
               rsp_slot_ff   <= slot_ff[SLOT_FIELD_W-1:0];
               rsp_sector_ff <= '0;
               rsp_last_ff   <= 1'b1;
            end
         endcase
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_slot   = rsp_slot_ff;
   assign rsp_sector = rsp_sector_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_last   = rsp_last_ff;

endmodule
`default_nettype wire

// File: src/swap_slot_bitmap_allocator_top.sv
// First-fit swap slot allocator with one used bit per slot.
// req channel: tuser[0] is the operation (0 allocate, 1 release), tdata[9:0] the
// slot to release. rsp channel: one transaction per page sector on success, the
// final one with tlast; a single transaction with tlast on error. tuser carries
// the status (0 ok, 1 store full, 2 slot not in use or out of range).
// The slot count register sits at byte address 0 of the csr port.
// A release reads the bitmap row of the requested slot and checks its used bit;
// an allocate scans from row 0, reading one 32-slot row of the bitmap memory per
// cycle, and stops at the row that holds the lowest free slot. The sector run of
// a result is paced by the single output register.
// Reset: the bitmap memory is cleared one row per cycle, all ceil(MAX_SLOTS/32)
// rows (32 at the default), while req_tready stays low; csr writes are taken.
// Stall: a result waits in the output register while rsp_tready is low and the
// run pauses; the next request is taken once the last result is registered.
`default_nettype none
module swap_slot_bitmap_allocator_top
   import ssba_pkg::*;
#(
   parameter int unsigned MAX_SLOTS        = 1024,
   parameter int unsigned SECTORS_PER_PAGE = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [15:0]           req_tdata,   // slot_index, zero fill
   input  wire logic [0:0]            req_tuser,   // operation
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic      [23:0]           rsp_tdata,   // slot, sector_address, zero fill
   output logic      [1:0]            rsp_tuser,   // status
   output logic                       rsp_tlast,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   logic [COUNT_FIELD_W-1:0]  slot_count_ff;
   cmd_type                   cmd;
   sts_type                   sts;
   logic [SLOT_FIELD_W-1:0]   rsp_slot;
   logic [SECTOR_FIELD_W-1:0] rsp_sector;
   status_type                rsp_status;

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff <= SLOT_COUNT_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   csr_paddr[CSR_ADDR_W-1] == REG_SLOT_COUNT) begin
         slot_count_ff <= csr_pwdata[COUNT_FIELD_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1] == REG_SLOT_COUNT) ?
                       CSR_DATA_W'(slot_count_ff) : '0;

   ssba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_op    (req_tuser[0]),
      .req_ready (req_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ssba_dpath #(
      .MAX_SLOTS        (MAX_SLOTS),
      .SECTORS_PER_PAGE (SECTORS_PER_PAGE)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .slot_count     (slot_count_ff),
      .req_slot_index (req_tdata[SLOT_FIELD_W-1:0]),
      .rsp_ready      (rsp_tready),
      .rsp_valid      (rsp_tvalid),
      .rsp_slot       (rsp_slot),
      .rsp_sector     (rsp_sector),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, rsp_sector, rsp_slot};
   assign rsp_tuser = rsp_status;

endmodule
`default_nettype wire

// File: src/ssba_checker.sv
`default_nettype none
module ssba_checker
   import ssba_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic [15:0]           req_tdata,
   input wire logic [0:0]            req_tuser,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [23:0]           rsp_tdata,
   input wire logic [1:0]            rsp_tuser,
   input wire logic                  rsp_tlast,
   input wire logic                  csr_psel,
   input wire logic                  csr_penable,
   input wire logic                  csr_pwrite,
   input wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input wire logic [CSR_DATA_W-1:0] csr_pwdata,
   input wire logic [CSR_DATA_W-1:0] csr_prdata,
   input wire logic                  csr_pready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   a_error_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STATUS_OK |-> rsp_tlast)
      else $error("error result without last mark");

   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STATUS_FULL |-> rsp_tdata == 24'd0)
      else $error("store full result carries data");

   a_clear_blocks: assert property (@(posedge clock)
      $past(reset) && !reset |-> !req_tready)
      else $error("request taken during bitmap clear");

endmodule

bind swap_slot_bitmap_allocator_top ssba_checker u_checker (.*);
`default_nettype wire

// File: bench/slot_map_pkg.sv
package slot_map_pkg;
   import ssba_pkg::*;

   localparam int unsigned MAP_SLOTS  = 1024;
   localparam int unsigned RUN_BEATS  = 8;

   typedef struct packed {
      logic [SLOT_FIELD_W-1:0]   slot;
      logic [SECTOR_FIELD_W-1:0] sector;
      status_type                status;
      logic                      last;
   } sector_beat_type;

   class slot_map_model;
      bit                     used [MAP_SLOTS];
      int unsigned            slot_limit;
      sector_beat_type        awaited [$];
      int unsigned            mismatches;

      function new();
         foreach (used[i]) used[i] = 1'b0;
         slot_limit = SLOT_COUNT_RESET;
         mismatches = 0;
      endfunction

      function void write_reg(int unsigned index, logic [CSR_DATA_W-1:0] value);
         if (index == REG_SLOT_COUNT) slot_limit = value[COUNT_FIELD_W-1:0];
      endfunction

      function int unsigned usable();
         return (slot_limit > MAP_SLOTS) ? MAP_SLOTS : slot_limit;
      endfunction

      function int unsigned outstanding();
         return awaited.size();
      endfunction

      function void push_run(int unsigned s);
         sector_beat_type b;
         for (int i = 0; i < RUN_BEATS; i++) begin
            b.slot   = SLOT_FIELD_W'(s);
            b.sector = SECTOR_FIELD_W'(s * RUN_BEATS + i);
            b.status = STATUS_OK;
            b.last   = (i == RUN_BEATS - 1);
            awaited.push_back(b);
         end
      endfunction

      function void push_error(logic [SLOT_FIELD_W-1:0] s, status_type st);
         sector_beat_type b;
         b.slot   = s;
         b.sector = '0;
         b.status = st;
         b.last   = 1'b1;
         awaited.push_back(b);
      endfunction

      // Advance the slot map for one accepted request.
      function void take_request(op_type op, logic [SLOT_FIELD_W-1:0] idx);
         int unsigned lim;
         lim = usable();
         if (op == OP_ALLOC) begin
            for (int unsigned s = 0; s < lim; s++) begin
               if (!used[s]) begin
                  used[s] = 1'b1;
                  push_run(s);
                  return;
               end
            end
            push_error('0, STATUS_FULL);
         end else begin
            if (idx >= lim || !used[idx]) begin
               push_error(idx, STATUS_BAD_SLOT);
            end else begin
               push_run(idx);
               used[idx] = 1'b0;
            end
         end
      endfunction

      function int pick_used();
         int q [$];
         foreach (used[i]) if (used[i]) q.push_back(i);
         if (q.size() == 0) return -1;
         return q[$urandom_range(0, q.size() - 1)];
      endfunction

      function void match_sector(sector_beat_type got);
         sector_beat_type want;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: slot=%0d sector=%0d status=%0d last=%0b",
                        got.slot, got.sector, got.status, got.last);
            return;
         end
         want = awaited.pop_front();
         if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"result mismatch: expected slot=%0d sector=%0d status=%0d last=%0b,",
                         " got slot=%0d sector=%0d status=%0d last=%0b"},
                        want.slot, want.sector, want.status, want.last,
                        got.slot, got.sector, got.status, got.last);
         end
      endfunction
   endclass

endpackage

// File: bench/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ssba_pkg::*;
   import slot_map_pkg::*;

   localparam int unsigned REG_UNMAPPED = 1;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [15:0]           req_tdata;
   logic [0:0]            req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [23:0]           rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   slot_map_model sb = new();
   bit            calm = 1'b0;
   bit            hold_request = 1'b0;
   int unsigned   hold_left = 0;

   swap_slot_bitmap_allocator_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

   // Receiver: random back-pressure, calm stretches, and one long hold-off.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left == 0 && hold_request) begin
            hold_left    = 300;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (calm) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= 36);
         end
      end
   end

   always @(posedge clock) begin
      sector_beat_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.slot   = rsp_tdata[SLOT_FIELD_W-1:0];
         got.sector = rsp_tdata[SLOT_FIELD_W +: SECTOR_FIELD_W];
         got.status = status_type'(rsp_tuser);
         got.last   = rsp_tlast;
         sb.match_sector(got);
      end
   end

   task automatic send_item(op_type op, logic [SLOT_FIELD_W-1:0] idx);
      while (!calm && $urandom_range(0, 99) < 36) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, idx};
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      sb.take_request(op, idx);
      @(negedge clock);
   endtask

   task automatic csr_write(int unsigned index, logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(index * 4);
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.write_reg(index, value);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Drop valid and wait until every awaited result has arrived.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic random_phase(int unsigned count, int unsigned n);
      int unsigned r;
      int          pick;
      int unsigned lim;
      csr_write(REG_SLOT_COUNT, count);
      for (int unsigned k = 0; k < n; k++) begin
         r = $urandom_range(0, 99);
         if (r < 45) begin
            send_item(OP_ALLOC, SLOT_FIELD_W'($urandom_range(0, 1023)));
         end else if (r < 80) begin
            pick = sb.pick_used();
            if (pick >= 0) send_item(OP_RELEASE, SLOT_FIELD_W'(pick));
            else send_item(OP_ALLOC, SLOT_FIELD_W'($urandom_range(0, 1023)));
         end else if (r < 92) begin
            send_item(OP_RELEASE, SLOT_FIELD_W'($urandom_range(0, 1023)));
         end else begin
            lim = sb.usable();
            if (lim >= MAP_SLOTS) lim = MAP_SLOTS - 1;
            if (r < 96 && lim > 0) lim = lim - 1;
            send_item(OP_RELEASE, SLOT_FIELD_W'(lim));
         end
      end
      settle();
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      send_item(OP_RELEASE, 10'd0);
      send_item(OP_ALLOC,   10'd0);
      send_item(OP_ALLOC,   10'h3FF);
      send_item(OP_RELEASE, 10'd1);
      send_item(OP_RELEASE, 10'd1);
      send_item(OP_RELEASE, 10'h3FF);
      send_item(OP_ALLOC,   10'd0);
      send_item(OP_ALLOC,   10'd0);
      settle();

      csr_write(REG_SLOT_COUNT, 32'd0);
      send_item(OP_ALLOC,   10'd0);
      send_item(OP_RELEASE, 10'd0);
      settle();

      csr_write(REG_SLOT_COUNT, 32'd3);
      send_item(OP_ALLOC,   10'd0);
      send_item(OP_RELEASE, 10'd2);
      send_item(OP_ALLOC,   10'd0);
      send_item(OP_RELEASE, 10'd0);
      send_item(OP_RELEASE, 10'd1);
      settle();

      csr_write(REG_SLOT_COUNT, 32'd2047);
      send_item(OP_ALLOC,   10'd0);
      send_item(OP_RELEASE, 10'h3FF);
      send_item(OP_ALLOC,   10'd0);
      settle();

      csr_write(REG_UNMAPPED, 32'd0);
      send_item(OP_ALLOC,   10'd0);
      send_item(OP_RELEASE, 10'd2);
      settle();

      hold_request = 1'b1;
      random_phase(16, 45);
      random_phase(3, 40);
      calm = 1'b1;
      random_phase(40, 50);
      calm = 1'b0;
      random_phase(7, 40);
      random_phase(1024, 50);
      random_phase(2047, 40);
      random_phase(1, 30);
      random_phase(0, 20);
      random_phase(100, 50);

      repeat (40) @(posedge clock);
      if (sb.mismatches == 0 && sb.outstanding() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
